/* rtl/dceta_pkg.sv */
// shared types and constants for the channel energy/time accumulator
package dceta_pkg;

	localparam int unsigned SEG_W      = 5;
	localparam int unsigned EXT_W      = 24;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned ENERGY_W   = 24;
	localparam int unsigned TRACK_W    = 20;
	localparam int unsigned CHAN_W     = 12;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// binning numerator 2*pos + extent on x and y, pos - front on z, signed
	localparam int unsigned NUM_W   = 35;
	localparam int unsigned DEN_W   = 26;
	localparam int unsigned BIN_W   = 4;
	localparam int unsigned ACC_W   = 9;
	// shared divider: divisor and partial remainder width, low word width
	localparam int unsigned DIV_W   = 25;
	localparam int unsigned DIVLO_W = 32;
	localparam int unsigned STEP_W  = 6;
	localparam int unsigned PROD_W  = DIV_W + BIN_W;
	localparam int unsigned TPROD_W = TIME_W + ENERGY_W;
	localparam int unsigned TNUM_W  = TPROD_W + 1;
	localparam int unsigned DATA_W  = TRACK_W + TIME_W + ENERGY_W;

	localparam logic [STEP_W-1:0] BIN_STEPS  = STEP_W'(BIN_W);
	localparam logic [STEP_W-1:0] TIME_STEPS = STEP_W'(DIVLO_W);
	localparam logic [STEP_W-1:0] MOD_STEPS  = STEP_W'(CHAN_W);

	localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

	localparam logic REQ_EVENT = 1'b1;

	localparam logic [SEG_W-1:0] SEG_QUAD = 5'd2;

	// quadrant map by sign of x and y
	localparam logic [CHAN_W-1:0] QUAD_PP = 12'd0;
	localparam logic [CHAN_W-1:0] QUAD_NP = 12'd1;
	localparam logic [CHAN_W-1:0] QUAD_NN = 12'd2;
	localparam logic [CHAN_W-1:0] QUAD_PN = 12'd3;

	localparam logic [SEG_W-1:0]  RST_SEGMENTS_X = 5'd2;
	localparam logic [SEG_W-1:0]  RST_SEGMENTS_Y = 5'd2;
	localparam logic [SEG_W-1:0]  RST_SEGMENTS_Z = 5'd1;
	localparam logic [EXT_W-1:0]  RST_EXTENT_X   = 24'd74240;
	localparam logic [EXT_W-1:0]  RST_EXTENT_Y   = 24'd74240;
	localparam logic [EXT_W-1:0]  RST_EXTENT_Z   = 24'd25600;
	localparam logic [POS_W-1:0]  RST_FRONT_Z    = 32'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEGMENTS_X = 3'd0,
		CFG_SEGMENTS_Y = 3'd1,
		CFG_SEGMENTS_Z = 3'd2,
		CFG_EXTENT_X   = 3'd3,
		CFG_EXTENT_Y   = 3'd4,
		CFG_EXTENT_Z   = 3'd5,
		CFG_FRONT_Z    = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BIN_SETUP,
		ST_BIN_CHECK,
		ST_BIN_DIV,
		ST_BIN_WAIT,
		ST_CHAN_A,
		ST_CHAN_B,
		ST_MOD_CHECK,
		ST_MOD_WAIT,
		ST_READ,
		ST_MUL_A,
		ST_MUL_B,
		ST_TSUM,
		ST_TDIV,
		ST_TWAIT,
		ST_WRITE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                start;
		logic [STEP_W-1:0]   steps;
		logic [DIV_W-1:0]    rem_init;
		logic [DIVLO_W-1:0]  low_init;
		logic [DIV_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIVLO_W-1:0]  quo;
		logic [DIV_W-1:0]    rem;
	} div_rsp_t;

endpackage

/* rtl/dceta_div.sv */
// shared restoring divider, one quotient bit per cycle
module dceta_div (
	input  logic                clk,
	input  logic                arst_n,
	input  dceta_pkg::div_req_t req,
	output dceta_pkg::div_rsp_t rsp
);
	import dceta_pkg::*;

	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIVLO_W-1:0] low_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_W:0]     trial;
	logic [DIV_W:0]     diff;
	logic               fits;

	// the partial remainder stays below the divisor, so trial fits one extra bit
	always_comb begin
		trial = {rem_q, low_q[DIVLO_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			low_q <= req.low_init;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			low_q <= {low_q[DIVLO_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = low_q;
	assign rsp.rem  = rem_q;

endmodule

/* rtl/detector_channel_energy_time_accumulator.sv */
// top level: deposit binning, channel store and energy-weighted time update
// Usage:
// Input channel (in_valid/in_stall) takes one item at a time: either an event
// start or an energy deposit with position, time, energy and track number.
// Every item gives exactly one result on the output channel (out_valid/out_stall).
// A deposit is binned into a channel on three axes (or by quadrant of sign when
// x and y both have two segments), the channel entry is read, its energy-weighted
// mean time and saturating energy sum are updated and written back.
// A deposit takes one binning division per axis, each clamped axis skipping
// its division; the quadrant map skips binning and a zero-energy deposit skips
// all work; a channel index at or above MAX_CHANNELS adds a modulo division.
// The three binning divisions (4 steps each) and the 32-step time division
// all run on one shared restoring divider; in_stall drops in the same cycle
// that the result is registered, so the next item waits for that result.
// An event start clears every channel valid bit in a pass over all MAX_CHANNELS
// entries before its result, and in_stall stays high meanwhile.
// After reset the same clearing pass runs before the first item is taken;
// configuration writes are taken at any time.
// A stalled result is held in the output register; the block still accepts the
// next item and works on it, waiting only to hand over its own result.
module detector_channel_energy_time_accumulator #(
	parameter int unsigned MAX_CHANNELS = 4096,
	parameter int unsigned MAX_SEGMENTS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [dceta_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dceta_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   req_type,
	input  logic signed [dceta_pkg::POS_W-1:0]     pos_x,
	input  logic signed [dceta_pkg::POS_W-1:0]     pos_y,
	input  logic signed [dceta_pkg::POS_W-1:0]     pos_z,
	input  logic [dceta_pkg::TIME_W-1:0]           hit_time,
	input  logic [dceta_pkg::ENERGY_W-1:0]         deposit_energy,
	input  logic [dceta_pkg::TRACK_W-1:0]          track_number,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   accepted,
	output logic [dceta_pkg::CHAN_W-1:0]           channel,
	output logic                                   first_in_channel,
	output logic [dceta_pkg::ENERGY_W-1:0]         energy_sum,
	output logic [dceta_pkg::TIME_W-1:0]           mean_time,
	output logic [dceta_pkg::TRACK_W-1:0]          first_track
);
	import dceta_pkg::*;

	localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam logic [AW-1:0]     LAST_ADDR = AW'(MAX_CHANNELS - 1);
	localparam logic [CHAN_W:0]   CHAN_LIMIT = (CHAN_W + 1)'(MAX_CHANNELS);
	localparam logic [SEG_W-1:0]  SEG_LIMIT = SEG_W'(MAX_SEGMENTS);

	// configuration
	logic [SEG_W-1:0] segments_x_q, segments_y_q, segments_z_q;
	logic [EXT_W-1:0] extent_x_q, extent_y_q, extent_z_q;
	logic [POS_W-1:0] front_z_q;

	logic [SEG_W-1:0] sx, sy, sz;
	logic [EXT_W-1:0] ex, ey, ez;

	// control
	state_t         state_q, state_d;
	axis_t          axis_q;
	logic           evt_q;
	logic           deposit_q;
	logic [AW-1:0]  clr_q;
	logic           out_valid_q;

	// latched item
	logic [POS_W-1:0]    px_q, py_q, pz_q;
	logic [TIME_W-1:0]   t_q;
	logic [ENERGY_W-1:0] e_q;
	logic [TRACK_W-1:0]  trk_in_q;

	// binning datapath
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [SEG_W-1:0]  seg_q;
	logic [PROD_W-1:0] prod_q;
	logic [BIN_W-1:0]  bin_q [3];
	logic [ACC_W-1:0]  acc_q;
	logic [CHAN_W-1:0] ch_q;
	logic              bin_neg;
	logic              bin_ge;
	logic              quad;

	// update datapath
	logic                first_q;
	logic [ENERGY_W-1:0] eo_q;
	logic [TIME_W-1:0]   to_q;
	logic [TRACK_W-1:0]  trk_q;
	logic [TPROD_W-1:0]  prod_a_q, prod_b_q;
	logic [TNUM_W-1:0]   tnum_q;
	logic [DIV_W-1:0]    tden_q;
	logic [ENERGY_W-1:0] en_q;
	logic [TIME_W-1:0]   tn_q;

	// channel store
	logic [DATA_W-1:0] data_mem [MAX_CHANNELS];
	logic              vld_mem  [MAX_CHANNELS];
	logic [DATA_W-1:0] rd_data_q;
	logic              rd_vld_q;
	logic [AW-1:0]     mem_addr;
	logic              data_we;
	logic              vld_we;
	logic              vld_wdata;

	// output register
	logic                accepted_q;
	logic [CHAN_W-1:0]   channel_q;
	logic                first_out_q;
	logic [ENERGY_W-1:0] energy_out_q;
	logic [TIME_W-1:0]   time_out_q;
	logic [TRACK_W-1:0]  track_out_q;
	logic                out_free;

	div_req_t div_req;
	div_rsp_t div_rsp;

	dceta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segments_x_q <= RST_SEGMENTS_X;
			segments_y_q <= RST_SEGMENTS_Y;
			segments_z_q <= RST_SEGMENTS_Z;
			extent_x_q   <= RST_EXTENT_X;
			extent_y_q   <= RST_EXTENT_Y;
			extent_z_q   <= RST_EXTENT_Z;
			front_z_q    <= RST_FRONT_Z;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SEGMENTS_X: segments_x_q <= cfg_data[SEG_W-1:0];
				CFG_SEGMENTS_Y: segments_y_q <= cfg_data[SEG_W-1:0];
				CFG_SEGMENTS_Z: segments_z_q <= cfg_data[SEG_W-1:0];
				CFG_EXTENT_X:   extent_x_q   <= cfg_data[EXT_W-1:0];
				CFG_EXTENT_Y:   extent_y_q   <= cfg_data[EXT_W-1:0];
				CFG_EXTENT_Z:   extent_z_q   <= cfg_data[EXT_W-1:0];
				CFG_FRONT_Z:    front_z_q    <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// zero segments act as one, too many as the maximum; zero extent acts as one
	always_comb begin
		sx = (segments_x_q == '0) ? SEG_W'(1) :
			((segments_x_q > SEG_LIMIT) ? SEG_LIMIT : segments_x_q);
		sy = (segments_y_q == '0) ? SEG_W'(1) :
			((segments_y_q > SEG_LIMIT) ? SEG_LIMIT : segments_y_q);
		sz = (segments_z_q == '0) ? SEG_W'(1) :
			((segments_z_q > SEG_LIMIT) ? SEG_LIMIT : segments_z_q);
		ex = (extent_x_q == '0) ? EXT_W'(1) : extent_x_q;
		ey = (extent_y_q == '0) ? EXT_W'(1) : extent_y_q;
		ez = (extent_z_q == '0) ? EXT_W'(1) : extent_z_q;
	end

	assign quad     = (segments_x_q == SEG_QUAD) && (segments_y_q == SEG_QUAD);
	assign bin_neg  = num_q[NUM_W-1];
	assign bin_ge   = (num_q[NUM_W-2:0] >= (NUM_W - 1)'(den_q));
	assign out_free = !out_valid_q || !out_stall;

	// sequencer
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		data_we   = 1'b0;
		vld_we    = 1'b0;
		vld_wdata = 1'b0;
		mem_addr  = ch_q[AW-1:0];
		div_req   = '{start: 1'b0, steps: BIN_STEPS,
			rem_init: prod_q[PROD_W-1:BIN_W],
			low_init: {prod_q[BIN_W-1:0], {(DIVLO_W - BIN_W){1'b0}}},
			divisor: den_q[DIV_W-1:0]};
		unique case (state_q)
			ST_CLEAR: begin
				mem_addr = clr_q;
				vld_we   = 1'b1;
				if (clr_q == LAST_ADDR) begin
					state_d = evt_q ? ST_RESULT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (req_type == REQ_EVENT) begin
						state_d = ST_CLEAR;
					end else if (deposit_energy == '0) begin
						state_d = ST_RESULT;
					end else if (quad) begin
						state_d = ST_MOD_CHECK;
					end else begin
						state_d = ST_BIN_SETUP;
					end
				end
			end
			ST_BIN_SETUP: begin
				state_d = ST_BIN_CHECK;
			end
			ST_BIN_CHECK: begin
				if (bin_neg || bin_ge) begin
					state_d = (axis_q == AXIS_Z) ? ST_CHAN_A : ST_BIN_SETUP;
				end else begin
					state_d = ST_BIN_DIV;
				end
			end
			ST_BIN_DIV: begin
				div_req.start = 1'b1;
				state_d       = ST_BIN_WAIT;
			end
			ST_BIN_WAIT: begin
				if (div_rsp.done) begin
					state_d = (axis_q == AXIS_Z) ? ST_CHAN_A : ST_BIN_SETUP;
				end
			end
			ST_CHAN_A: begin
				state_d = ST_CHAN_B;
			end
			ST_CHAN_B: begin
				state_d = ST_MOD_CHECK;
			end
			ST_MOD_CHECK: begin
				div_req.steps    = MOD_STEPS;
				div_req.rem_init = '0;
				div_req.low_init = {ch_q, {(DIVLO_W - CHAN_W){1'b0}}};
				div_req.divisor  = DIV_W'(MAX_CHANNELS);
				if ({1'b0, ch_q} >= CHAN_LIMIT) begin
					div_req.start = 1'b1;
					state_d       = ST_MOD_WAIT;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_MOD_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_MUL_A;
			end
			ST_MUL_A: begin
				state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				state_d = ST_TSUM;
			end
			ST_TSUM: begin
				state_d = ST_TDIV;
			end
			ST_TDIV: begin
				div_req.start    = 1'b1;
				div_req.steps    = TIME_STEPS;
				div_req.rem_init = tnum_q[TNUM_W-1:DIVLO_W];
				div_req.low_init = tnum_q[DIVLO_W-1:0];
				div_req.divisor  = tden_q;
				state_d          = ST_TWAIT;
			end
			ST_TWAIT: begin
				if (div_rsp.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				data_we   = 1'b1;
				vld_we    = 1'b1;
				vld_wdata = 1'b1;
				state_d   = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			evt_q       <= 1'b0;
			deposit_q   <= 1'b0;
			axis_q      <= AXIS_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
			end
			if (state_q == ST_IDLE && in_valid) begin
				evt_q     <= (req_type == REQ_EVENT);
				deposit_q <= (req_type != REQ_EVENT) && (deposit_energy != '0);
				axis_q    <= AXIS_X;
			end
			if ((state_q == ST_BIN_CHECK && (bin_neg || bin_ge)) ||
				(state_q == ST_BIN_WAIT && div_rsp.done)) begin
				unique case (axis_q)
					AXIS_X: axis_q <= AXIS_Y;
					AXIS_Y: axis_q <= AXIS_Z;
					default: axis_q <= AXIS_Z;
				endcase
			end
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
				evt_q       <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				px_q     <= pos_x;
				py_q     <= pos_y;
				pz_q     <= pos_z;
				t_q      <= hit_time;
				e_q      <= deposit_energy;
				trk_in_q <= track_number;
				priority if (!pos_x[POS_W-1] && !pos_y[POS_W-1]) begin
					ch_q <= QUAD_PP;
				end else if (!pos_y[POS_W-1]) begin
					ch_q <= QUAD_NP;
				end else if (pos_x[POS_W-1]) begin
					ch_q <= QUAD_NN;
				end else begin
					ch_q <= QUAD_PN;
				end
			end
			ST_BIN_SETUP: begin
				unique case (axis_q)
					AXIS_X: begin
						num_q <= {{(NUM_W - POS_W - 1){px_q[POS_W-1]}}, px_q, 1'b0} +
							NUM_W'(ex);
						den_q <= DEN_W'({ex, 1'b0});
						seg_q <= sx;
					end
					AXIS_Y: begin
						num_q <= {{(NUM_W - POS_W - 1){py_q[POS_W-1]}}, py_q, 1'b0} +
							NUM_W'(ey);
						den_q <= DEN_W'({ey, 1'b0});
						seg_q <= sy;
					end
					default: begin
						num_q <= {{(NUM_W - POS_W){pz_q[POS_W-1]}}, pz_q} -
							{{(NUM_W - POS_W){front_z_q[POS_W-1]}}, front_z_q};
						den_q <= DEN_W'(ez);
						seg_q <= sz;
					end
				endcase
			end
			ST_BIN_CHECK: begin
				// below zero bins to the first segment, at or past the far edge to the last
				if (bin_neg) begin
					bin_q[axis_q] <= '0;
				end else if (bin_ge) begin
					bin_q[axis_q] <= BIN_W'(seg_q - SEG_W'(1));
				end
				prod_q <= PROD_W'(num_q[DIV_W-1:0] * seg_q);
			end
			ST_BIN_WAIT: begin
				if (div_rsp.done) begin
					bin_q[axis_q] <= div_rsp.quo[BIN_W-1:0];
				end
			end
			ST_CHAN_A: begin
				acc_q <= ACC_W'(sy * bin_q[AXIS_Z]) + ACC_W'(bin_q[AXIS_Y]);
			end
			ST_CHAN_B: begin
				ch_q <= CHAN_W'(sx * acc_q) + CHAN_W'(bin_q[AXIS_X]);
			end
			ST_MOD_WAIT: begin
				if (div_rsp.done) begin
					ch_q <= div_rsp.rem[CHAN_W-1:0];
				end
			end
			ST_MUL_A: begin
				// a fresh channel starts from zero time and energy
				first_q  <= !rd_vld_q;
				eo_q     <= rd_vld_q ? rd_data_q[ENERGY_W-1:0] : '0;
				to_q     <= rd_vld_q ? rd_data_q[ENERGY_W +: TIME_W] : '0;
				trk_q    <= rd_vld_q ? rd_data_q[DATA_W-1 -: TRACK_W] : trk_in_q;
				prod_a_q <= t_q * e_q;
			end
			ST_MUL_B: begin
				prod_b_q <= to_q * eo_q;
			end
			ST_TSUM: begin
				tnum_q <= TNUM_W'(prod_a_q) + TNUM_W'(prod_b_q);
				tden_q <= DIV_W'(e_q) + DIV_W'(eo_q);
				en_q   <= (({1'b0, e_q} + {1'b0, eo_q}) > {1'b0, ENERGY_MAX}) ? ENERGY_MAX :
					e_q + eo_q;
			end
			ST_TWAIT: begin
				if (div_rsp.done) begin
					tn_q <= div_rsp.quo;
				end
			end
			default: ;
		endcase
	end

	// channel store, registered read
	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[mem_addr] <= {trk_q, tn_q, en_q};
		end
		if (vld_we) begin
			vld_mem[mem_addr] <= vld_wdata;
		end
		rd_data_q <= data_mem[mem_addr];
		rd_vld_q  <= vld_mem[mem_addr];
	end

	// result transfer
	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			accepted_q   <= deposit_q;
			channel_q    <= deposit_q ? ch_q : '0;
			first_out_q  <= deposit_q && first_q;
			energy_out_q <= deposit_q ? en_q : '0;
			time_out_q   <= deposit_q ? tn_q : '0;
			track_out_q  <= deposit_q ? trk_q : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = accepted_q;
	assign channel          = channel_q;
	assign first_in_channel = first_out_q;
	assign energy_sum       = energy_out_q;
	assign mean_time        = time_out_q;
	assign first_track      = track_out_q;

endmodule
